// ===== src/spira_pkg.sv =====
// Package for the SPI register-access master: phase, action and register codes.
// Used by spi_register_access_master_unit; no other dependencies.
package spira_pkg;

   localparam int unsigned HalfBitWidth = 10;
   localparam int unsigned GapWidth     = 16;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned AddrWidth    = 7;
   localparam int unsigned BitCntWidth  = 4;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [HalfBitWidth-1:0] HALF_BIT_RESET   = 10'd8;
   localparam logic [GapWidth-1:0]     READ_GAP_RESET   = 16'd800;
   localparam logic [GapWidth-1:0]     BURST_GAP_RESET  = 16'd120;
   localparam logic [BitCntWidth-1:0]  BITS_PER_BYTE    = 4'd8;
   localparam logic [ByteWidth-1:0]    ADDR_WRITE_FLAG  = 8'h80;
   localparam logic [ByteWidth-1:0]    ADDR_READ_MASK   = 8'h7f;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR,
      PH_GAP,
      PH_RX,
      PH_TX,
      PH_BGAP,
      PH_FINISH
   } phase_type;

   typedef enum logic [2:0] {
      ACT_REG_WRITE,
      ACT_REG_READ,
      ACT_BYTE_OUT,
      ACT_BYTE_IN,
      ACT_SET_SELECT
   } action_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_HALF_BIT,
      CSR_READ_GAP,
      CSR_BURST_GAP
   } csr_index_type;

endpackage

// ===== src/spi_register_access_master_unit.sv =====
// SPI mode-3 register-access master: serial engine, config registers, result register.
// Depends on spira_pkg for phase, action and register codes.
//
// The result of a transaction on req_ is registered and appears on rsp_ in the cycle after acceptance.
// Throughput: one transaction per cycle while req_stall is low; each req transaction is one
//   engine tick, and the next-state logic feeds the rsp output register directly.
// req_stall rises only while a finished result sits in the output register under rsp_stall.
// Reset (synchronous, active high): engine idle, engine SCLK level and select high, config registers
//   back to half bit 8, read gap 800, burst gap 120; rsp_valid cleared.
module spi_register_access_master_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel: one transaction per engine tick
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_req,
   input  logic [2:0]                          req_action,
   input  logic [spira_pkg::AddrWidth-1:0]     req_reg_address,
   input  logic [spira_pkg::ByteWidth-1:0]     req_write_byte,
   input  logic                                req_miso,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_sclk,
   output logic                                rsp_mosi,
   output logic                                rsp_select_n,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [spira_pkg::ByteWidth-1:0]     rsp_read_byte,
   // configuration write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spira_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [spira_pkg::CsrDataWidth-1:0]  csr_data
);

   // ---------------------------------------------------------------------------------
   // Configuration registers. Writes are always taken; an unused index is dropped.
   // ---------------------------------------------------------------------------------
   logic [spira_pkg::HalfBitWidth-1:0] half_bit_ff;
   logic [spira_pkg::GapWidth-1:0]     read_gap_ff;
   logic [spira_pkg::GapWidth-1:0]     burst_gap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff  <= spira_pkg::HALF_BIT_RESET;
         read_gap_ff  <= spira_pkg::READ_GAP_RESET;
         burst_gap_ff <= spira_pkg::BURST_GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (spira_pkg::csr_index_type'(csr_index))
            spira_pkg::CSR_HALF_BIT:  half_bit_ff  <= csr_data[spira_pkg::HalfBitWidth-1:0];
            spira_pkg::CSR_READ_GAP:  read_gap_ff  <= csr_data;
            spira_pkg::CSR_BURST_GAP: burst_gap_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Engine state
   // ---------------------------------------------------------------------------------
   spira_pkg::phase_type                phase_ff,   phase_in;
   logic [spira_pkg::BitCntWidth-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [spira_pkg::ByteWidth-1:0]     shift_ff,   shift_in;
   logic [spira_pkg::GapWidth-1:0]      timer_ff,   timer_in;
   logic [spira_pkg::ByteWidth-1:0]     pending_ff, pending_in;
   spira_pkg::action_type               kind_ff,    kind_in;
   logic                                select_ff,  select_in;
   logic                                sclk_lvl_ff, sclk_lvl_in;

   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                sclk_ff, sclk_in;
   logic                                mosi_ff, mosi_in;
   logic                                select_n_ff;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [spira_pkg::ByteWidth-1:0]     read_byte_ff, read_byte_in;

   logic                                accept;
   logic [spira_pkg::HalfBitWidth-1:0]  half_eff;
   spira_pkg::phase_type                tick_phase;

   // The output register is the only buffer: stall the request side only while a
   // result is held there by the consumer.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // zero half-bit count runs as one
   assign half_eff = (half_bit_ff == '0) ? {{(spira_pkg::HalfBitWidth-1){1'b0}}, 1'b1}
                                         : half_bit_ff;

   // ---------------------------------------------------------------------------------
   // One engine tick: launch from idle, then advance whatever phase is current.
   // ---------------------------------------------------------------------------------
   always_comb begin
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      timer_in    = timer_ff;
      pending_in  = pending_ff;
      kind_in     = kind_ff;
      select_in   = select_ff;
      sclk_lvl_in = sclk_lvl_ff;

      sclk_in      = 1'b1;
      mosi_in      = 1'b0;
      busy_in      = 1'b0;
      done_in      = 1'b0;
      read_byte_in = '0;

      // launch: the accepting tick is already the first low tick of the byte
      if (phase_ff == spira_pkg::PH_IDLE && req_start_req) begin
         unique case (req_action)
            spira_pkg::ACT_SET_SELECT: begin
               select_in = req_write_byte[0];
               kind_in   = spira_pkg::ACT_SET_SELECT;
               done_in   = 1'b1;
            end
            spira_pkg::ACT_REG_WRITE, spira_pkg::ACT_REG_READ,
            spira_pkg::ACT_BYTE_OUT, spira_pkg::ACT_BYTE_IN: begin
               kind_in     = spira_pkg::action_type'(req_action);
               pending_in  = req_write_byte;
               bit_cnt_in  = '0;
               timer_in    = '0;
               sclk_lvl_in = 1'b0;
               unique case (req_action)
                  spira_pkg::ACT_REG_WRITE: begin
                     phase_in = spira_pkg::PH_ADDR;
                     shift_in = {1'b0, req_reg_address} | spira_pkg::ADDR_WRITE_FLAG;
                  end
                  spira_pkg::ACT_REG_READ: begin
                     phase_in = spira_pkg::PH_ADDR;
                     shift_in = {1'b0, req_reg_address} & spira_pkg::ADDR_READ_MASK;
                  end
                  spira_pkg::ACT_BYTE_OUT: begin
                     phase_in = spira_pkg::PH_TX;
                     shift_in = req_write_byte;
                  end
                  default: begin
                     phase_in = spira_pkg::PH_RX;
                     shift_in = '0;
                  end
               endcase
            end
            default: ;  // undefined action codes start nothing
         endcase
      end

      tick_phase = phase_in;

      unique case (tick_phase)
         spira_pkg::PH_ADDR, spira_pkg::PH_TX, spira_pkg::PH_RX: begin
            sclk_in = sclk_lvl_in;
            mosi_in = (tick_phase != spira_pkg::PH_RX) & shift_in[spira_pkg::ByteWidth-1];
            busy_in = 1'b1;
            // sample MISO on the rising edge (first high tick)
            if (tick_phase == spira_pkg::PH_RX && sclk_lvl_in && timer_in == '0)
               shift_in = {shift_in[spira_pkg::ByteWidth-2:0], req_miso};
            timer_in = timer_in + 16'd1;
            if (timer_in >= {{(spira_pkg::GapWidth-spira_pkg::HalfBitWidth){1'b0}},
                             half_eff}) begin
               timer_in = '0;
               if (!sclk_lvl_in) begin
                  sclk_lvl_in = 1'b1;
               end else begin
                  sclk_lvl_in = 1'b0;
                  if (tick_phase != spira_pkg::PH_RX)
                     shift_in = {shift_in[spira_pkg::ByteWidth-2:0], 1'b0};
                  bit_cnt_in = bit_cnt_in + 4'd1;
                  if (bit_cnt_in >= spira_pkg::BITS_PER_BYTE) begin
                     // end of byte
                     priority if (tick_phase == spira_pkg::PH_ADDR) begin
                        if (kind_in == spira_pkg::ACT_REG_WRITE) begin
                           phase_in    = spira_pkg::PH_TX;
                           shift_in    = pending_in;
                           bit_cnt_in  = '0;
                           sclk_lvl_in = 1'b0;
                        end else if (read_gap_ff == '0) begin
                           phase_in    = spira_pkg::PH_RX;
                           shift_in    = '0;
                           bit_cnt_in  = '0;
                           sclk_lvl_in = 1'b0;
                        end else begin
                           phase_in    = spira_pkg::PH_GAP;
                           sclk_lvl_in = 1'b1;
                        end
                     end else if ((tick_phase == spira_pkg::PH_TX &&
                                   kind_in == spira_pkg::ACT_BYTE_OUT) ||
                                  (tick_phase == spira_pkg::PH_RX &&
                                   kind_in == spira_pkg::ACT_BYTE_IN)) begin
                        sclk_lvl_in = 1'b1;
                        phase_in    = (burst_gap_ff == '0) ? spira_pkg::PH_FINISH
                                                           : spira_pkg::PH_BGAP;
                     end else begin
                        phase_in    = spira_pkg::PH_FINISH;
                        sclk_lvl_in = 1'b1;
                     end
                  end
               end
            end
         end
         spira_pkg::PH_GAP: begin
            busy_in  = 1'b1;
            timer_in = timer_in + 16'd1;
            if (timer_in >= read_gap_ff) begin
               phase_in    = spira_pkg::PH_RX;
               shift_in    = '0;
               bit_cnt_in  = '0;
               timer_in    = '0;
               sclk_lvl_in = 1'b0;
            end
         end
         spira_pkg::PH_BGAP: begin
            busy_in  = 1'b1;
            timer_in = timer_in + 16'd1;
            if (timer_in >= burst_gap_ff) begin
               phase_in = spira_pkg::PH_FINISH;
               timer_in = '0;
            end
         end
         spira_pkg::PH_FINISH: begin
            done_in = 1'b1;
            if (kind_in == spira_pkg::ACT_REG_READ || kind_in == spira_pkg::ACT_BYTE_IN)
               read_byte_in = shift_in;
            phase_in    = spira_pkg::PH_IDLE;
            sclk_lvl_in = 1'b1;
         end
         default: begin
            phase_in    = spira_pkg::PH_IDLE;
            sclk_lvl_in = 1'b1;
         end
      endcase
   end

   // engine state advances only on an accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= spira_pkg::PH_IDLE;
         bit_cnt_ff  <= '0;
         shift_ff    <= '0;
         timer_ff    <= '0;
         pending_ff  <= '0;
         kind_ff     <= spira_pkg::ACT_REG_WRITE;
         select_ff   <= 1'b1;
         sclk_lvl_ff <= 1'b1;
      end else if (accept) begin
         phase_ff    <= phase_in;
         bit_cnt_ff  <= bit_cnt_in;
         shift_ff    <= shift_in;
         timer_ff    <= timer_in;
         pending_ff  <= pending_in;
         kind_ff     <= kind_in;
         select_ff   <= select_in;
         sclk_lvl_ff <= sclk_lvl_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------------
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sclk_ff      <= sclk_in;
         mosi_ff      <= mosi_in;
         select_n_ff  <= select_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         read_byte_ff <= read_byte_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sclk      = sclk_ff;
   assign rsp_mosi      = mosi_ff;
   assign rsp_select_n  = select_n_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_read_byte = read_byte_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(done_ff && busy_ff))
      else $error("done and busy reported together");

   a_read_byte_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && read_byte_ff != '0) |-> done_ff)
      else $error("read byte nonzero outside a done tick");

   a_serial_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (mosi_ff || !sclk_ff)) |-> busy_ff)
      else $error("serial lines active while not busy");

   a_finish_gives_done: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == spira_pkg::PH_FINISH) |=> (rsp_valid_ff && done_ff))
      else $error("finish tick without done");

   a_stall_holds_engine: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !$past(reset)) |=> $stable(phase_ff))
      else $error("engine advanced while stalled");

endmodule
